/* rtl/dsm_pkg.sv */
// Shared definitions for the DWARF expression stack machine.
// Holds command and status codes, the controller state type and the
// control and status structs. Depends on nothing.
package dsm_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic [15:0] LIMIT_RESET = 16'd10000;

    localparam logic [5:0] CMD_PUSH_CONST = 6'd0;
    localparam logic [5:0] CMD_PUSH_ADDR  = 6'd1;
    localparam logic [5:0] CMD_DUP        = 6'd2;
    localparam logic [5:0] CMD_DROP       = 6'd3;
    localparam logic [5:0] CMD_OVER       = 6'd4;
    localparam logic [5:0] CMD_PICK       = 6'd5;
    localparam logic [5:0] CMD_SWAP       = 6'd6;
    localparam logic [5:0] CMD_ROT        = 6'd7;
    localparam logic [5:0] CMD_ABS        = 6'd8;
    localparam logic [5:0] CMD_AND        = 6'd9;
    localparam logic [5:0] CMD_DIV        = 6'd10;
    localparam logic [5:0] CMD_MINUS      = 6'd11;
    localparam logic [5:0] CMD_MOD        = 6'd12;
    localparam logic [5:0] CMD_MUL        = 6'd13;
    localparam logic [5:0] CMD_NEG        = 6'd14;
    localparam logic [5:0] CMD_NOT        = 6'd15;
    localparam logic [5:0] CMD_OR         = 6'd16;
    localparam logic [5:0] CMD_PLUS       = 6'd17;
    localparam logic [5:0] CMD_PLUS_UCONST = 6'd18;
    localparam logic [5:0] CMD_SHL        = 6'd19;
    localparam logic [5:0] CMD_SHR        = 6'd20;
    localparam logic [5:0] CMD_SHRA       = 6'd21;
    localparam logic [5:0] CMD_XOR        = 6'd22;
    localparam logic [5:0] CMD_EQ         = 6'd23;
    localparam logic [5:0] CMD_GE         = 6'd24;
    localparam logic [5:0] CMD_GT         = 6'd25;
    localparam logic [5:0] CMD_LE         = 6'd26;
    localparam logic [5:0] CMD_LT         = 6'd27;
    localparam logic [5:0] CMD_NE         = 6'd28;
    localparam logic [5:0] CMD_BRA        = 6'd29;
    localparam logic [5:0] CMD_SKIP       = 6'd30;
    localparam logic [5:0] CMD_NOP        = 6'd31;
    localparam logic [5:0] CMD_FINISH     = 6'd32;
    localparam logic [5:0] CMD_CLEAR      = 6'd33;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_LIMIT = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_NARROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_DIV,
        UOP_MOD
    } uop_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RD1   = 8'b00000010,
        S_RD2   = 8'b00000100,
        S_RD3   = 8'b00001000,
        S_CHECK = 8'b00010000,
        S_UNIT  = 8'b00100000,
        S_WR    = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    typedef struct packed {
        logic       load_in;
        logic       rd_sel;
        logic       cap_b;
        logic       cap_c;
        logic       check;
        logic       unit_start;
        logic       unit_take;
        logic       wr_en;
        logic [1:0] wr_idx;
        logic       commit;
    } ctl_t;

    typedef struct packed {
        logic       go;
        logic       use_unit;
        logic [1:0] n_wr;
        logic       unit_done;
        logic       out_free;
    } sts_t;

    typedef struct packed {
        logic [1:0] need;
        logic [1:0] pops;
        logic       push;
        logic [1:0] n_wr;
        logic       unit;
    } op_t;

    function automatic op_t decode(input logic [5:0] cmd);
        op_t o;
        o = '0;
        case (cmd) inside
            CMD_PUSH_CONST, CMD_PUSH_ADDR, CMD_PICK:
            begin
                o.push = 1'b1;
                o.n_wr = 2'd1;
            end
            CMD_DUP:
            begin
                o.need = 2'd1;
                o.push = 1'b1;
                o.n_wr = 2'd1;
            end
            CMD_OVER:
            begin
                o.need = 2'd2;
                o.push = 1'b1;
                o.n_wr = 2'd1;
            end
            CMD_DROP, CMD_BRA:
            begin
                o.need = 2'd1;
                o.pops = 2'd1;
            end
            CMD_SWAP:
            begin
                o.need = 2'd2;
                o.n_wr = 2'd2;
            end
            CMD_ROT:
            begin
                o.need = 2'd3;
                o.n_wr = 2'd3;
            end
            CMD_ABS, CMD_NEG, CMD_NOT, CMD_PLUS_UCONST:
            begin
                o.need = 2'd1;
                o.pops = 2'd1;
                o.push = 1'b1;
                o.n_wr = 2'd1;
            end
            [CMD_AND:CMD_NE]:
            begin
                o.need = 2'd2;
                o.pops = 2'd2;
                o.push = 1'b1;
                o.n_wr = 2'd1;
                o.unit = (cmd == CMD_DIV) || (cmd == CMD_MOD) || (cmd == CMD_MUL);
            end
            default:
            begin
                o = '0;
            end
        endcase
        return o;
    endfunction

endpackage

/* rtl/dsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the value stack. Depends on nothing.
module dsm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/dsm_muldiv.sv */
// Iterative multiply, signed divide and unsigned modulo, one bit per cycle.
// Depends on dsm_pkg.
module dsm_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  dsm_pkg::uop_t    op,
    input  logic [63:0]      lhs,
    input  logic [63:0]      rhs,
    output logic             done,
    output logic [63:0]      result
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [5:0]          cnt_reg, cnt_next;
    dsm_pkg::uop_t       op_reg, op_next;
    logic [63:0]         m_reg, m_next;
    logic [63:0]         q_reg, q_next;
    logic [63:0]         acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic                zero_reg, zero_next;
    logic [64:0]         shifted;
    logic [64:0]         diff;

    assign shifted = {acc_reg, q_reg[63]};
    assign diff    = shifted - {1'b0, m_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        m_next    = m_reg;
        q_next    = q_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = op;
            acc_next  = '0;
            zero_next = (rhs == 64'd0);
            neg_next  = lhs[63] ^ rhs[63];
            if (op == dsm_pkg::UOP_DIV)
            begin
                q_next = lhs[63] ? (~lhs + 64'd1) : lhs;
                m_next = rhs[63] ? (~rhs + 64'd1) : rhs;
            end
            else if (op == dsm_pkg::UOP_MOD)
            begin
                q_next = lhs;
                m_next = rhs;
            end
            else
            begin
                q_next = rhs;
                m_next = lhs;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == dsm_pkg::UOP_MUL)
            begin
                if (q_reg[0])
                begin
                    acc_next = acc_reg + m_reg;
                end
                m_next = {m_reg[62:0], 1'b0};
                q_next = {1'b0, q_reg[63:1]};
            end
            else if (shifted >= {1'b0, m_reg})
            begin
                acc_next = diff[63:0];
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                acc_next = shifted[63:0];
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        m_reg    <= m_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    always_comb
    begin
        case (op_reg)
            dsm_pkg::UOP_MUL: result = acc_reg;
            dsm_pkg::UOP_DIV: result = zero_reg ? 64'd0 :
                                       (neg_reg ? (~q_reg + 64'd1) : q_reg);
            dsm_pkg::UOP_MOD: result = zero_reg ? 64'd0 : acc_reg;
            default:          result = 64'd0;
        endcase
    end

    assign done = done_reg;

endmodule

/* rtl/dsm_datapath.sv */
// Datapath: configuration, stack pointer, cached top of stack, checks,
// operation results, stack RAM and the result register.
// Depends on dsm_pkg, dsm_ram and dsm_muldiv.
module dsm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsm_pkg::ctl_t                 ctl,
    output dsm_pkg::sts_t                 sts,
    input  logic [5:0]                    command,
    input  logic [63:0]                   operand,
    input  logic                          cfg_we,
    input  logic [dsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [63:0]                   value,
    output logic [10:0]                   stack_depth,
    output logic                          branch_taken
);

    localparam int AW = dsm_pkg::ADDR_W;
    localparam int DW = dsm_pkg::DEPTH_W;

    logic                 narrow_reg;
    logic [63:0]          delta_reg;
    logic [15:0]          limit_reg;
    logic [5:0]           cmd_reg;
    logic [63:0]          opnd_reg;
    logic [DW-1:0]        depth_reg, depth_next;
    logic [15:0]          opcnt_reg, opcnt_next;
    logic [63:0]          tos_reg, tos_next;
    logic [63:0]          b_reg;
    logic [63:0]          c_reg;
    logic [63:0]          pv_reg;
    logic [2:0]           st_reg;
    logic                 go_reg;
    logic                 taken_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           out_st_reg;
    logic [63:0]          out_val_reg;
    logic [DW-1:0]        out_depth_reg;
    logic                 out_taken_reg;

    dsm_pkg::op_t         op;
    logic [2:0]           st_c;
    logic                 go_c;
    logic                 taken_c;
    logic [63:0]          pv_c;
    logic [63:0]          xs;
    logic [63:0]          xr;
    logic [DW-1:0]        d_pop;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;
    logic [63:0]          wdata;
    logic [63:0]          rdata;
    logic [DW-1:0]        pick_addr;
    logic                 unit_done;
    logic [63:0]          unit_res;
    dsm_pkg::uop_t        uop;
    logic                 shamt_big;

    assign op        = dsm_pkg::decode(cmd_reg);
    assign d_pop     = depth_reg - {{(DW-2){1'b0}}, op.pops};
    assign pick_addr = depth_reg - DW'(1) - {1'b0, opnd_reg[AW-1:0]};
    assign raddr     = ctl.rd_sel ? AW'(depth_reg - DW'(3))
                                  : ((cmd_reg == dsm_pkg::CMD_PICK) ? pick_addr[AW-1:0]
                                                                    : AW'(depth_reg - DW'(2)));
    assign shamt_big = (tos_reg[63:6] != 58'd0);

    always_comb
    begin
        st_c    = dsm_pkg::ST_OK;
        go_c    = 1'b0;
        taken_c = 1'b0;
        if (cmd_reg == dsm_pkg::CMD_FINISH)
        begin
            if (depth_reg == '0)
            begin
                st_c = dsm_pkg::ST_UNDER;
            end
            else
            begin
                go_c = 1'b1;
            end
        end
        else if (cmd_reg == dsm_pkg::CMD_CLEAR)
        begin
            go_c = 1'b1;
        end
        else if (cmd_reg > dsm_pkg::CMD_CLEAR)
        begin
            st_c = dsm_pkg::ST_BAD;
        end
        else if (opcnt_reg >= limit_reg)
        begin
            st_c = dsm_pkg::ST_LIMIT;
        end
        else if ((cmd_reg == dsm_pkg::CMD_PICK) ? (opnd_reg >= 64'(depth_reg))
                                                : (depth_reg < DW'(op.need)))
        begin
            st_c = dsm_pkg::ST_UNDER;
        end
        else if (op.push && (d_pop >= DW'(dsm_pkg::STACK_DEPTH)))
        begin
            st_c = dsm_pkg::ST_OVER;
        end
        else
        begin
            go_c    = 1'b1;
            taken_c = ((cmd_reg == dsm_pkg::CMD_BRA) && (tos_reg != 64'd0))
                      || (cmd_reg == dsm_pkg::CMD_SKIP);
            if (({1'b0, opcnt_reg} + 17'd1) >= {1'b0, limit_reg})
            begin
                st_c = dsm_pkg::ST_LIMIT;
            end
        end
    end

    always_comb
    begin
        xs = narrow_reg ? {{32{tos_reg[31]}}, tos_reg[31:0]} : tos_reg;
        xr = ((cmd_reg == dsm_pkg::CMD_NEG) || xs[63]) ? (~xs + 64'd1) : xs;
        if (narrow_reg)
        begin
            xr = {{32{xr[31]}}, xr[31:0]};
        end
        case (cmd_reg)
            dsm_pkg::CMD_PUSH_CONST:  pv_c = opnd_reg;
            dsm_pkg::CMD_PUSH_ADDR:   pv_c = opnd_reg + delta_reg;
            dsm_pkg::CMD_DUP:         pv_c = tos_reg;
            dsm_pkg::CMD_OVER:        pv_c = b_reg;
            dsm_pkg::CMD_PICK:        pv_c = b_reg;
            dsm_pkg::CMD_ABS:         pv_c = xr;
            dsm_pkg::CMD_NEG:         pv_c = xr;
            dsm_pkg::CMD_NOT:         pv_c = ~tos_reg;
            dsm_pkg::CMD_PLUS_UCONST: pv_c = tos_reg + opnd_reg;
            dsm_pkg::CMD_AND:         pv_c = b_reg & tos_reg;
            dsm_pkg::CMD_OR:          pv_c = b_reg | tos_reg;
            dsm_pkg::CMD_XOR:         pv_c = b_reg ^ tos_reg;
            dsm_pkg::CMD_MINUS:       pv_c = b_reg - tos_reg;
            dsm_pkg::CMD_PLUS:        pv_c = b_reg + tos_reg;
            dsm_pkg::CMD_SHL:         pv_c = shamt_big ? 64'd0 : (b_reg << tos_reg[5:0]);
            dsm_pkg::CMD_SHR:         pv_c = shamt_big ? 64'd0 : (b_reg >> tos_reg[5:0]);
            dsm_pkg::CMD_SHRA:        pv_c = shamt_big ? {64{b_reg[63]}}
                                                       : 64'($signed(b_reg) >>> tos_reg[5:0]);
            dsm_pkg::CMD_EQ:          pv_c = 64'(b_reg == tos_reg);
            dsm_pkg::CMD_NE:          pv_c = 64'(b_reg != tos_reg);
            dsm_pkg::CMD_GE:          pv_c = 64'($signed(b_reg) >= $signed(tos_reg));
            dsm_pkg::CMD_GT:          pv_c = 64'($signed(b_reg) > $signed(tos_reg));
            dsm_pkg::CMD_LE:          pv_c = 64'($signed(b_reg) <= $signed(tos_reg));
            dsm_pkg::CMD_LT:          pv_c = 64'($signed(b_reg) < $signed(tos_reg));
            default:                  pv_c = 64'd0;
        endcase
    end

    always_comb
    begin
        case (cmd_reg)
            dsm_pkg::CMD_DIV: uop = dsm_pkg::UOP_DIV;
            dsm_pkg::CMD_MOD: uop = dsm_pkg::UOP_MOD;
            default:          uop = dsm_pkg::UOP_MUL;
        endcase
    end

    always_comb
    begin
        waddr = AW'(depth_reg - DW'(2));
        wdata = pv_reg;
        if (cmd_reg == dsm_pkg::CMD_SWAP)
        begin
            waddr = (ctl.wr_idx == 2'd0) ? AW'(depth_reg - DW'(1)) : AW'(depth_reg - DW'(2));
            wdata = (ctl.wr_idx == 2'd0) ? b_reg : tos_reg;
        end
        else if (cmd_reg == dsm_pkg::CMD_ROT)
        begin
            case (ctl.wr_idx)
                2'd0:
                begin
                    waddr = AW'(depth_reg - DW'(1));
                    wdata = b_reg;
                end
                2'd1:
                begin
                    waddr = AW'(depth_reg - DW'(2));
                    wdata = c_reg;
                end
                default:
                begin
                    waddr = AW'(depth_reg - DW'(3));
                    wdata = tos_reg;
                end
            endcase
        end
        else if (op.pops == 2'd0)
        begin
            waddr = depth_reg[AW-1:0];
        end
        else if (op.pops == 2'd1)
        begin
            waddr = AW'(depth_reg - DW'(1));
        end
    end

    always_comb
    begin
        depth_next = depth_reg;
        opcnt_next = opcnt_reg;
        tos_next   = tos_reg;
        if (go_reg)
        begin
            case (cmd_reg)
                dsm_pkg::CMD_CLEAR:
                begin
                    depth_next = '0;
                    opcnt_next = '0;
                    tos_next   = 64'd0;
                end
                dsm_pkg::CMD_FINISH:
                begin
                    depth_next = depth_reg - DW'(1);
                    opcnt_next = '0;
                    tos_next   = (depth_reg >= DW'(2)) ? b_reg : 64'd0;
                end
                default:
                begin
                    depth_next = d_pop + DW'(op.push);
                    opcnt_next = opcnt_reg + 16'd1;
                    case (cmd_reg)
                        dsm_pkg::CMD_DROP, dsm_pkg::CMD_BRA:
                            tos_next = (depth_reg >= DW'(2)) ? b_reg : 64'd0;
                        dsm_pkg::CMD_SWAP, dsm_pkg::CMD_ROT:
                            tos_next = b_reg;
                        dsm_pkg::CMD_SKIP, dsm_pkg::CMD_NOP:
                            tos_next = tos_reg;
                        default:
                            tos_next = pv_reg;
                    endcase
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            narrow_reg    <= 1'b0;
            delta_reg     <= 64'd0;
            limit_reg     <= dsm_pkg::LIMIT_RESET;
            depth_reg     <= '0;
            opcnt_reg     <= '0;
            tos_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dsm_pkg::CFG_NARROW: narrow_reg <= cfg_data[0];
                    dsm_pkg::CFG_DELTA:  delta_reg  <= cfg_data;
                    dsm_pkg::CFG_LIMIT:  limit_reg  <= cfg_data[15:0];
                    default:             narrow_reg <= narrow_reg;
                endcase
            end
            if (ctl.commit)
            begin
                depth_reg <= depth_next;
                opcnt_reg <= opcnt_next;
                tos_reg   <= tos_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg  <= command;
            opnd_reg <= operand;
        end
        if (ctl.cap_b)
        begin
            b_reg <= rdata;
        end
        if (ctl.cap_c)
        begin
            c_reg <= rdata;
        end
        if (ctl.check)
        begin
            st_reg    <= st_c;
            go_reg    <= go_c;
            taken_reg <= taken_c;
            pv_reg    <= pv_c;
        end
        else if (ctl.unit_take)
        begin
            pv_reg <= unit_res;
        end
        if (ctl.commit)
        begin
            out_st_reg    <= st_reg;
            out_val_reg   <= ((cmd_reg == dsm_pkg::CMD_FINISH) && go_reg) ? tos_reg : tos_next;
            out_depth_reg <= depth_next;
            out_taken_reg <= taken_reg;
        end
    end

    dsm_ram #(
        .WIDTH(64),
        .DEPTH(dsm_pkg::STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ctl.wr_en),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    dsm_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.unit_start),
        .op    (uop),
        .lhs   (b_reg),
        .rhs   (tos_reg),
        .done  (unit_done),
        .result(unit_res)
    );

    assign sts.go        = go_c;
    assign sts.use_unit  = op.unit;
    assign sts.n_wr      = op.n_wr;
    assign sts.unit_done = unit_done;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign status       = out_st_reg;
    assign value        = out_val_reg;
    assign stack_depth  = 11'(out_depth_reg);
    assign branch_taken = out_taken_reg;

endmodule

/* rtl/dsm_ctrl.sv */
// Controller state machine that sequences stack reads, checks, the
// multiply and divide unit, stack writes and the result. Depends on dsm_pkg.
module dsm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  dsm_pkg::sts_t sts,
    output dsm_pkg::ctl_t ctl
);

    dsm_pkg::state_t state_reg, state_next;
    logic [1:0]      wr_idx_reg, wr_idx_next;

    always_comb
    begin
        state_next  = state_reg;
        wr_idx_next = wr_idx_reg;
        ctl         = '0;
        ctl.wr_idx  = wr_idx_reg;
        case (state_reg)
            dsm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = dsm_pkg::S_RD1;
                end
            end
            dsm_pkg::S_RD1:
            begin
                state_next = dsm_pkg::S_RD2;
            end
            dsm_pkg::S_RD2:
            begin
                ctl.cap_b  = 1'b1;
                ctl.rd_sel = 1'b1;
                state_next = dsm_pkg::S_RD3;
            end
            dsm_pkg::S_RD3:
            begin
                ctl.cap_c  = 1'b1;
                state_next = dsm_pkg::S_CHECK;
            end
            dsm_pkg::S_CHECK:
            begin
                ctl.check   = 1'b1;
                wr_idx_next = 2'd0;
                if (sts.go && sts.use_unit)
                begin
                    ctl.unit_start = 1'b1;
                    state_next     = dsm_pkg::S_UNIT;
                end
                else if (sts.go && (sts.n_wr != 2'd0))
                begin
                    state_next = dsm_pkg::S_WR;
                end
                else
                begin
                    state_next = dsm_pkg::S_OUT;
                end
            end
            dsm_pkg::S_UNIT:
            begin
                if (sts.unit_done)
                begin
                    ctl.unit_take = 1'b1;
                    state_next    = dsm_pkg::S_WR;
                end
            end
            dsm_pkg::S_WR:
            begin
                ctl.wr_en = 1'b1;
                if (wr_idx_reg == (sts.n_wr - 2'd1))
                begin
                    state_next = dsm_pkg::S_OUT;
                end
                else
                begin
                    wr_idx_next = wr_idx_reg + 2'd1;
                end
            end
            dsm_pkg::S_OUT:
            begin
                if (sts.out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = dsm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dsm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dsm_pkg::S_IDLE;
            wr_idx_reg <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_idx_reg <= wr_idx_next;
        end
    end

    assign in_stall = (state_reg != dsm_pkg::S_IDLE);

endmodule

/* rtl/dwarf_expression_stack_machine.sv */
// Top level of the DWARF expression stack machine.
// Joins the controller and the datapath. Depends on dsm_pkg, dsm_ctrl
// and dsm_datapath.
//
// One request on the input channel carries a decoded command and its
// operand; each request yields exactly one request on the output channel
// with status, value, stack depth and branch flag. A request is taken when
// valid is high and stall is low. The configuration channel writes the
// address mode, relocation delta and operation limit; write it only while
// the block is idle. cfg_ready is always high.
// An item is taken, then states RD1, RD2 and RD3 read the stack RAM (its
// single read port sets this), CHECK checks and computes, WR writes the
// stack zero to three times, and OUT loads the result register. Multiply,
// divide and modulo also wait in state UNIT for the bit-serial unit.
// One item is in flight at a time.
// Reset empties the stack, clears the operation count and loads the
// default configuration; no clearing pass is needed. When the receiver
// stalls, the result is held and the next input is taken, but its result
// waits until the held one has been taken.
module dwarf_expression_stack_machine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [5:0]                    command,
    input  logic [63:0]                   operand,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [63:0]                   value,
    output logic [10:0]                   stack_depth,
    output logic                          branch_taken,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);

    dsm_pkg::ctl_t ctl;
    dsm_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    dsm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts     (sts),
        .ctl     (ctl)
    );

    dsm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .command     (command),
        .operand     (operand),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .value       (value),
        .stack_depth (stack_depth),
        .branch_taken(branch_taken)
    );

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the DWARF expression stack machine.
// Drives decoded stack commands with random bursts and output stalls, predicts
// every result in a behavioral stack model and compares field by field. Needs dsm_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [5:0]  cmd;
        logic [63:0] opnd;
        bit          is_cfg;
        logic [1:0]  cidx;
        logic [63:0] cdata;
    } request_t;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] value;
        logic [10:0] depth;
        logic        taken;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [5:0] command = '0;
    logic [63:0] operand = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] status;
    logic [63:0] value;
    logic [10:0] stack_depth;
    logic branch_taken;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [dsm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    request_t pending[$];
    outcome_t expected_results[$];
    logic [63:0] model_stack[dsm_pkg::STACK_DEPTH];
    int unsigned model_depth = 0;
    int unsigned model_ops = 0;
    logic model_narrow = 1'b0;
    logic [63:0] model_delta = '0;
    logic [15:0] model_limit = dsm_pkg::LIMIT_RESET;
    int errors = 0;
    int accepted = 0;
    int checked = 0;
    int idle_cycles = 0;

    dwarf_expression_stack_machine dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] sext32(logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [63:0] binary_result(logic [5:0] c, logic [63:0] l, logic [63:0] r);
        logic signed [63:0] sl;
        logic signed [63:0] sr;
        sl = l;
        sr = r;
        case (c)
            dsm_pkg::CMD_AND: return l & r;
            dsm_pkg::CMD_DIV:
            begin
                if (r == 0) return 0;
                if (l == 64'h8000_0000_0000_0000 && r == '1) return l;
                return sl / sr;
            end
            dsm_pkg::CMD_MINUS: return l - r;
            dsm_pkg::CMD_MOD: return (r != 0) ? l % r : 64'd0;
            dsm_pkg::CMD_MUL: return l * r;
            dsm_pkg::CMD_OR: return l | r;
            dsm_pkg::CMD_PLUS: return l + r;
            dsm_pkg::CMD_SHL: return (r >= 64) ? 64'd0 : l << r[5:0];
            dsm_pkg::CMD_SHR: return (r >= 64) ? 64'd0 : l >> r[5:0];
            dsm_pkg::CMD_SHRA: return (r >= 64) ? {64{l[63]}} : 64'(sl >>> r[5:0]);
            dsm_pkg::CMD_XOR: return l ^ r;
            dsm_pkg::CMD_EQ: return {63'd0, l == r};
            dsm_pkg::CMD_GE: return {63'd0, sl >= sr};
            dsm_pkg::CMD_GT: return {63'd0, sl > sr};
            dsm_pkg::CMD_LE: return {63'd0, sl <= sr};
            dsm_pkg::CMD_LT: return {63'd0, sl < sr};
            default: return {63'd0, l != r};
        endcase
    endfunction

    function automatic logic [63:0] entry(int unsigned back);
        if (back >= model_depth) return 0;
        return model_stack[model_depth - 1 - back];
    endfunction

    function automatic outcome_t predict_step(logic [5:0] c, logic [63:0] opnd);
        outcome_t o;
        int unsigned need;
        int unsigned pops;
        bit push;
        bit taken;
        logic [63:0] pv;
        logic [63:0] x;
        logic [63:0] t;
        bit have_val;
        logic [63:0] rv;
        need = 0;
        pops = 0;
        push = 0;
        taken = 0;
        pv = 0;
        have_val = 0;
        rv = 0;
        o.status = dsm_pkg::ST_OK;
        if (c == dsm_pkg::CMD_FINISH)
        begin
            if (model_depth == 0) o.status = dsm_pkg::ST_UNDER;
            else
            begin
                rv = entry(0);
                have_val = 1;
                model_depth--;
                model_ops = 0;
            end
        end
        else if (c == dsm_pkg::CMD_CLEAR)
        begin
            model_depth = 0;
            model_ops = 0;
        end
        else if (c > dsm_pkg::CMD_CLEAR) o.status = dsm_pkg::ST_BAD;
        else if (model_ops >= model_limit) o.status = dsm_pkg::ST_LIMIT;
        else
        begin
            case (c)
                dsm_pkg::CMD_PUSH_CONST:
                begin
                    push = 1;
                    pv = opnd;
                end
                dsm_pkg::CMD_PUSH_ADDR:
                begin
                    push = 1;
                    pv = opnd + model_delta;
                end
                dsm_pkg::CMD_DUP:
                begin
                    need = 1;
                    push = 1;
                    pv = entry(0);
                end
                dsm_pkg::CMD_DROP:
                begin
                    need = 1;
                    pops = 1;
                end
                dsm_pkg::CMD_OVER:
                begin
                    need = 2;
                    push = 1;
                    pv = entry(1);
                end
                dsm_pkg::CMD_PICK:
                begin
                    if (opnd >= model_depth) need = model_depth + 1;
                    else
                    begin
                        push = 1;
                        pv = entry(opnd);
                    end
                end
                dsm_pkg::CMD_SWAP: need = 2;
                dsm_pkg::CMD_ROT: need = 3;
                dsm_pkg::CMD_ABS, dsm_pkg::CMD_NEG, dsm_pkg::CMD_NOT,
                dsm_pkg::CMD_PLUS_UCONST:
                begin
                    need = 1;
                    pops = 1;
                    push = 1;
                    x = entry(0);
                    if (c == dsm_pkg::CMD_NOT) pv = ~x;
                    else if (c == dsm_pkg::CMD_PLUS_UCONST) pv = x + opnd;
                    else if (model_narrow)
                    begin
                        x = sext32(x);
                        pv = sext32((c == dsm_pkg::CMD_NEG || x[63]) ? -x : x);
                    end
                    else pv = (c == dsm_pkg::CMD_NEG || x[63]) ? -x : x;
                end
                dsm_pkg::CMD_BRA:
                begin
                    need = 1;
                    pops = 1;
                    taken = entry(0) != 0;
                end
                dsm_pkg::CMD_SKIP: taken = 1;
                dsm_pkg::CMD_NOP: ;
                default:
                begin
                    need = 2;
                    pops = 2;
                    push = 1;
                    pv = binary_result(c, entry(1), entry(0));
                end
            endcase
            if (model_depth < need)
            begin
                o.status = dsm_pkg::ST_UNDER;
                taken = 0;
            end
            else if (push && model_depth - pops >= dsm_pkg::STACK_DEPTH)
                o.status = dsm_pkg::ST_OVER;
            else
            begin
                if (c == dsm_pkg::CMD_SWAP)
                begin
                    t = model_stack[model_depth-1];
                    model_stack[model_depth-1] = model_stack[model_depth-2];
                    model_stack[model_depth-2] = t;
                end
                else if (c == dsm_pkg::CMD_ROT)
                begin
                    t = model_stack[model_depth-1];
                    model_stack[model_depth-1] = model_stack[model_depth-2];
                    model_stack[model_depth-2] = model_stack[model_depth-3];
                    model_stack[model_depth-3] = t;
                end
                model_depth -= pops;
                if (push) model_stack[model_depth++] = pv;
                model_ops++;
                if (model_ops >= model_limit) o.status = dsm_pkg::ST_LIMIT;
            end
        end
        if (o.status != dsm_pkg::ST_OK && o.status != dsm_pkg::ST_LIMIT) taken = 0;
        o.value = have_val ? rv : entry(0);
        o.depth = model_depth[10:0];
        o.taken = taken;
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'(int'($urandom_range(0, 70)));
            4: return {32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic add_cmd(logic [5:0] c, logic [63:0] o);
        request_t r;
        r = '{cmd: c, opnd: o, is_cfg: 0, cidx: 0, cdata: 0};
        pending.push_back(r);
    endtask

    task automatic add_cfg(logic [1:0] idx, logic [63:0] d);
        request_t r;
        r = '{cmd: 0, opnd: 0, is_cfg: 1, cidx: idx, cdata: d};
        pending.push_back(r);
    endtask

    // One expression: pushes, random operations that mostly keep the stack
    // populated, and usually a finish.
    task automatic add_expression();
        int n;
        int k;
        n = $urandom_range(2, 12);
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_cmd($urandom_range(0, 1) ? dsm_pkg::CMD_PUSH_CONST
                                                      : dsm_pkg::CMD_PUSH_ADDR, rand64());
                3: add_cmd(dsm_pkg::CMD_PICK, 64'($urandom_range(0, 4)));
                9: add_cmd(6'($urandom_range(0, 63)), rand64());
                default: add_cmd(6'($urandom_range(dsm_pkg::CMD_DUP, dsm_pkg::CMD_NOP)),
                                 rand64());
            endcase
        end
        if ($urandom_range(0, 3) != 0) add_cmd(dsm_pkg::CMD_FINISH, 0);
        else if ($urandom_range(0, 1)) add_cmd(dsm_pkg::CMD_CLEAR, 0);
    endtask

    // Driver: config writes wait for an empty scoreboard plus a quiet spell.
    always @(posedge clk or negedge rst_n)
    begin
        static int burst = 0;
        static int gap = 0;
        static int quiet = 0;
        request_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                r = pending.pop_front();
                case (r.cidx)
                    dsm_pkg::CFG_NARROW: model_narrow = r.cdata[0];
                    dsm_pkg::CFG_DELTA: model_delta = r.cdata;
                    default: model_limit = r.cdata[15:0];
                endcase
                cfg_valid <= 1'b0;
            end
            else if (in_valid && !in_stall)
            begin
                r = pending.pop_front();
                expected_results.push_back(predict_step(r.cmd, r.opnd));
                accepted++;
            end
            quiet = (expected_results.size() == 0 && !in_valid) ? quiet + 1 : 0;
            if (!(in_valid && in_stall) && !(cfg_valid && !cfg_ready))
            begin
                if (pending.size() == 0 || (cfg_valid && cfg_ready))
                begin
                    in_valid <= 1'b0;
                    cfg_valid <= 1'b0;
                end
                else if (pending[0].is_cfg)
                begin
                    in_valid <= 1'b0;
                    if (quiet > 80)
                    begin
                        cfg_valid <= 1'b1;
                        cfg_index <= pending[0].cidx;
                        cfg_data <= pending[0].cdata;
                    end
                end
                else if (gap > 0)
                begin
                    gap--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    command <= pending[0].cmd;
                    operand <= pending[0].opnd;
                    if (burst > 0) burst--;
                    else
                    begin
                        burst = $urandom_range(0, 20);
                        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // Monitor and receiver stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        static int phase = 0;
        outcome_t e;
        if (!rst_n) out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected request: status %0d value %h depth %0d", $time,
                             status, value, stack_depth);
                end
                else
                begin
                    e = expected_results.pop_front();
                    checked++;
                    if (status !== e.status)
                    begin
                        errors++;
                        $display("%0t status expected %0d actual %0d", $time, e.status, status);
                    end
                    if (value !== e.value)
                    begin
                        errors++;
                        $display("%0t value expected %h actual %h", $time, e.value, value);
                    end
                    if (stack_depth !== e.depth)
                    begin
                        errors++;
                        $display("%0t depth expected %0d actual %0d", $time, e.depth,
                                 stack_depth);
                    end
                    if (branch_taken !== e.taken)
                    begin
                        errors++;
                        $display("%0t branch expected %0d actual %0d", $time, e.taken,
                                 branch_taken);
                    end
                end
            end
            phase = (phase + 1) % 600;
            if (phase < 150) out_stall <= 1'b0;
            else if (phase < 400) out_stall <= ($urandom_range(0, 3) == 0);
            else out_stall <= ($urandom_range(0, 1) == 0) ? 1'b1 : ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || (pending.size() == 0 && expected_results.size() == 0))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Timeout with %0d results outstanding.", expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int k;
        // Directed part: a selection of commands, extremes, the corner cases.
        add_cmd(dsm_pkg::CMD_FINISH, 0);
        add_cmd(dsm_pkg::CMD_DROP, 0);
        add_cmd(dsm_pkg::CMD_PUSH_CONST, 64'h8000_0000_0000_0000);
        add_cmd(dsm_pkg::CMD_OVER, 0);
        add_cmd(dsm_pkg::CMD_PUSH_CONST, '1);
        add_cmd(dsm_pkg::CMD_DIV, 0);
        add_cmd(dsm_pkg::CMD_PUSH_CONST, 0);
        add_cmd(dsm_pkg::CMD_MOD, 0);
        add_cmd(dsm_pkg::CMD_PUSH_CONST, 64'h8000_0000_0000_0000);
        add_cmd(dsm_pkg::CMD_ABS, 0);
        add_cmd(dsm_pkg::CMD_NEG, 0);
        add_cmd(dsm_pkg::CMD_PICK, 5);
        add_cmd(dsm_pkg::CMD_PICK, 1);
        add_cmd(dsm_pkg::CMD_PUSH_ADDR, '1);
        add_cmd(dsm_pkg::CMD_ROT, 0);
        add_cmd(dsm_pkg::CMD_PUSH_CONST, 64);
        add_cmd(dsm_pkg::CMD_SHRA, 0);
        add_cmd(dsm_pkg::CMD_PUSH_CONST, 7);
        add_cmd(dsm_pkg::CMD_NE, 0);
        add_cmd(dsm_pkg::CMD_BRA, 0);
        add_cmd(dsm_pkg::CMD_SKIP, 0);
        add_cmd(6'd63, '1);
        add_cmd(dsm_pkg::CMD_CLEAR, 0);
        for (k = 0; k < 20; k++) add_expression();
        add_cfg(dsm_pkg::CFG_NARROW, 1);
        add_cfg(dsm_pkg::CFG_DELTA, '1);
        add_cfg(dsm_pkg::CFG_LIMIT, 1);
        add_cmd(dsm_pkg::CMD_PUSH_CONST, 64'h0000_0000_8000_0000);
        add_cmd(dsm_pkg::CMD_NEG, 0);
        add_cmd(dsm_pkg::CMD_FINISH, 0);
        add_cmd(dsm_pkg::CMD_PUSH_ADDR, 5);
        add_cmd(dsm_pkg::CMD_ABS, 0);
        add_cmd(dsm_pkg::CMD_CLEAR, 0);
        for (k = 0; k < 10; k++) add_expression();
        add_cfg(dsm_pkg::CFG_LIMIT, 16'hFFFF);
        add_cfg(dsm_pkg::CFG_DELTA, {$urandom(), $urandom()});
        for (k = 0; k < 1030; k++) add_cmd(dsm_pkg::CMD_PUSH_CONST, rand64());
        add_cmd(dsm_pkg::CMD_DUP, 0);
        add_cmd(dsm_pkg::CMD_PICK, 1023);
        add_cmd(dsm_pkg::CMD_ABS, 0);
        add_cmd(dsm_pkg::CMD_CLEAR, 0);
        add_cfg(dsm_pkg::CFG_LIMIT, 5);
        add_cfg(dsm_pkg::CFG_NARROW, 0);
        for (k = 0; k < 10; k++) add_expression();
        add_cfg(dsm_pkg::CFG_LIMIT, 16'd40);
        add_cfg(dsm_pkg::CFG_NARROW, 1);
        for (k = 0; k < 9; k++) add_expression();
        add_cmd(dsm_pkg::CMD_CLEAR, 0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending.size() == 0);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);
        $display("Checked %0d results from %0d accepted commands,", checked, accepted);
        $display("across address modes, relocation deltas, limits and a full stack.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* filelist.f */
rtl/dsm_pkg.sv
rtl/dsm_ram.sv
rtl/dsm_muldiv.sv
rtl/dsm_datapath.sv
rtl/dsm_ctrl.sv
rtl/dwarf_expression_stack_machine.sv
dv/tb_top.sv
